// ===== rtl/tls_client_hello_sni_extractor_top_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define TCH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that an implication holds in the cycle after the antecedent, outside reset.
`define TCH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tch_pkg.sv =====
`timescale 1ns / 1ps
package tch_pkg;

    // Buffer size and widths.
    localparam int unsigned BufferBytes = 16384;
    localparam int unsigned PosW = $clog2(BufferBytes) + 1;

    // Result status codes.
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NOT   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // Protocol constants.
    localparam logic [7:0] REC_HANDSHAKE = 8'h16;
    localparam logic [7:0] MIN_MAJOR     = 8'h03;
    localparam logic [7:0] MSG_HELLO     = 8'h01;
    localparam logic [7:0] MAX_SID       = 8'd32;
    localparam logic [16:0] LAST_RANDOM  = 17'd42;

endpackage

// ===== rtl/tls_client_hello_sni_extractor_top.sv =====
`timescale 1ns / 1ps
// TLS ClientHello server-name extractor.
// Input channel s_*: one buffer byte per item (s_data_byte) with s_first_byte
// marking the start of a buffer and s_last_byte the last byte available now.
// Result channel m_*: at most one result per buffer, with m_status (found,
// not a hello, too short), and for found the host name offset and length.
// Each input item is parsed by the phase logic in the cycle it is accepted;
// a result appears in the output register on the next cycle.
// Throughput is one byte per cycle: s_ready is high whenever the output
// register is empty or being taken in the same cycle, so a stalled receiver
// holds off the input for as long as a result waits in the output register.
// In practice a second result needs a new buffer, so s_ready drops only when
// the result register is full and m_ready is low.
// Reset (aresetn low, synchronous) acts as the start of a buffer and empties
// the result register. Bytes past the buffer size are ignored except that
// a last byte still reports too short.
module tls_client_hello_sni_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [13:0] m_name_offset,
    output logic [15:0] m_name_length
);
    import tch_pkg::*;
`include "tls_client_hello_sni_extractor_top_defines.svh"

    typedef enum logic [4:0] {
        PH_TYPE, PH_MAJOR, PH_MINOR, PH_RLEN_HI, PH_RLEN_LO, PH_MSG,
        PH_HLEN0, PH_HLEN1, PH_HLEN2, PH_CVER_MAJ, PH_CVER_MIN, PH_RANDOM,
        PH_SID_LEN, PH_SID, PH_CIPH_HI, PH_CIPH_LO, PH_CIPH, PH_COMP_LEN,
        PH_COMP, PH_EXTS_HI, PH_EXTS_LO, PH_EXT_TYPE_HI, PH_EXT_TYPE_LO,
        PH_EXT_LEN_HI, PH_EXT_LEN_LO, PH_SRV_HI, PH_SRV_LO, PH_NTYPE,
        PH_NLEN_HI, PH_NLEN_LO, PH_EXT_SKIP, PH_WAIT
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [16:0]  pos_reg, pos_next;
    logic [24:0]  hend_reg, hend_next;
    logic [23:0]  rem_reg, rem_next;
    logic [23:0]  acc_reg, acc_next;
    logic [1:0]   pend_reg, pend_next;
    logic [13:0]  foff_reg, foff_next;
    logic [15:0]  flen_reg, flen_next;
    logic         given_reg, given_next;
    logic         out_valid_reg;
    logic [1:0]   out_status_reg;
    logic [13:0]  out_off_reg;
    logic [15:0]  out_len_reg;

    logic         take;
    logic         emit;
    logic [1:0]   emit_code;

    assign s_ready       = !out_valid_reg || m_ready;
    assign take          = s_valid && s_ready;
    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_name_offset = out_off_reg;
    assign m_name_length = out_len_reg;

    // Per-byte parse step: phase update and verdict.
    always_comb begin
        logic [16:0] p;
        logic signed [26:0] r;
        logic [23:0] v;
        logic [23:0] lx;
        logic [23:0] rem_dec;
        logic        early;
        logic [1:0]  early_code;
        logic        restart;

        restart    = s_first_byte;
        phase_next = restart ? PH_TYPE : phase_reg;
        pos_next   = restart ? '0 : pos_reg;
        hend_next  = restart ? '0 : hend_reg;
        rem_next   = restart ? '0 : rem_reg;
        acc_next   = restart ? '0 : acc_reg;
        pend_next  = restart ? ST_NOT : pend_reg;
        foff_next  = restart ? '0 : foff_reg;
        flen_next  = restart ? '0 : flen_reg;
        given_next = restart ? 1'b0 : given_reg;
        emit       = 1'b0;
        emit_code  = ST_NOT;
        early      = 1'b0;
        early_code = ST_NOT;
        p          = pos_next;
        r          = $signed({2'b00, hend_next}) - $signed({10'd0, p}) - 27'sd1;
        rem_dec    = (rem_next != '0) ? rem_next - 24'd1 : rem_next;
        v          = '0;
        lx         = '0;

        if (!given_next && p < 17'(BufferBytes)) begin
            pos_next = p + 17'd1;
            unique case (phase_next)
                PH_TYPE: begin
                    if (s_data_byte != REC_HANDSHAKE) early = 1'b1;
                    else phase_next = PH_MAJOR;
                end
                PH_MAJOR: begin
                    if (s_data_byte < MIN_MAJOR) early = 1'b1;
                    else phase_next = PH_MINOR;
                end
                PH_MINOR: phase_next = PH_RLEN_HI;
                PH_RLEN_HI: begin
                    acc_next = {16'd0, s_data_byte};
                    phase_next = PH_RLEN_LO;
                end
                PH_RLEN_LO: begin
                    v = {8'd0, acc_next[7:0], s_data_byte};
                    if (v < 24'd49) early = 1'b1;
                    else phase_next = PH_MSG;
                end
                PH_MSG: begin
                    if (s_data_byte != MSG_HELLO) early = 1'b1;
                    else phase_next = PH_HLEN0;
                end
                PH_HLEN0: begin
                    acc_next = {16'd0, s_data_byte};
                    phase_next = PH_HLEN1;
                end
                PH_HLEN1: begin
                    acc_next = {acc_next[15:0], s_data_byte};
                    phase_next = PH_HLEN2;
                end
                PH_HLEN2: begin
                    v = {acc_next[15:0], s_data_byte};
                    if (v < 24'd45) early = 1'b1;
                    else begin
                        hend_next = {1'b0, v} + 25'd9;
                        phase_next = PH_CVER_MAJ;
                    end
                end
                PH_CVER_MAJ: begin
                    acc_next = (s_data_byte < MIN_MAJOR) ? 24'd1 : 24'd0;
                    phase_next = PH_CVER_MIN;
                end
                PH_CVER_MIN: begin
                    if (acc_next != '0 || s_data_byte < 8'd1) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else phase_next = PH_RANDOM;
                end
                PH_RANDOM: begin
                    if (p >= LAST_RANDOM) phase_next = PH_SID_LEN;
                end
                PH_SID_LEN: begin
                    if (s_data_byte > MAX_SID || $signed({19'd0, s_data_byte}) > r) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else if (s_data_byte == 8'd0) begin
                        if (r < 27'sd4) begin
                            pend_next = ST_NOT; phase_next = PH_WAIT;
                        end else phase_next = PH_CIPH_HI;
                    end else begin
                        rem_next = {16'd0, s_data_byte};
                        phase_next = PH_SID;
                    end
                end
                PH_SID: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        if (r < 27'sd4) begin
                            pend_next = ST_NOT; phase_next = PH_WAIT;
                        end else phase_next = PH_CIPH_HI;
                    end
                end
                PH_CIPH_HI: begin
                    acc_next = {16'd0, s_data_byte};
                    phase_next = PH_CIPH_LO;
                end
                PH_CIPH_LO: begin
                    v = {8'd0, acc_next[7:0], s_data_byte};
                    if (v < 24'd2 || $signed({3'd0, v}) > r + 27'sd2 ||
                        r - $signed({3'd0, v}) < 27'sd2) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else begin
                        rem_next = v; phase_next = PH_CIPH;
                    end
                end
                PH_CIPH: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) phase_next = PH_COMP_LEN;
                end
                PH_COMP_LEN: begin
                    if (s_data_byte < 8'd1 || $signed({19'd0, s_data_byte}) > r + 27'sd1 ||
                        r - $signed({19'd0, s_data_byte}) < 27'sd2) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else begin
                        rem_next = {16'd0, s_data_byte}; phase_next = PH_COMP;
                    end
                end
                PH_COMP: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) phase_next = PH_EXTS_HI;
                end
                PH_EXTS_HI: begin
                    acc_next = {16'd0, s_data_byte};
                    phase_next = PH_EXTS_LO;
                end
                PH_EXTS_LO: begin
                    v = {8'd0, acc_next[7:0], s_data_byte};
                    if ($signed({3'd0, v}) > r) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else begin
                        rem_next = v;
                        if (v < 24'd4) begin
                            pend_next = ST_NOT; phase_next = PH_WAIT;
                        end else phase_next = PH_EXT_TYPE_HI;
                    end
                end
                PH_EXT_TYPE_HI: begin
                    rem_next = rem_dec;
                    acc_next = {16'd0, s_data_byte};
                    phase_next = PH_EXT_TYPE_LO;
                end
                PH_EXT_TYPE_LO: begin
                    rem_next = rem_dec;
                    acc_next = ({acc_next[7:0], s_data_byte} == 16'd0) ? 24'h010000 : 24'd0;
                    phase_next = PH_EXT_LEN_HI;
                end
                PH_EXT_LEN_HI: begin
                    rem_next = rem_dec;
                    acc_next = {7'd0, acc_next[16], s_data_byte, 8'd0};
                    phase_next = PH_EXT_LEN_LO;
                end
                PH_EXT_LEN_LO: begin
                    rem_next = rem_dec;
                    lx = {8'd0, acc_next[15:8], s_data_byte};
                    if (lx > rem_dec) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else if (acc_next[16]) begin
                        if (lx < 24'd2) begin
                            pend_next = ST_NOT; phase_next = PH_WAIT;
                        end else begin
                            acc_next = {lx[15:0], 8'd0}; phase_next = PH_SRV_HI;
                        end
                    end else if (lx == '0) begin
                        if (rem_dec < 24'd4) begin
                            pend_next = ST_NOT; phase_next = PH_WAIT;
                        end else phase_next = PH_EXT_TYPE_HI;
                    end else begin
                        acc_next = lx; phase_next = PH_EXT_SKIP;
                    end
                end
                PH_SRV_HI: begin
                    rem_next = rem_dec;
                    acc_next = {acc_next[23:8], s_data_byte};
                    phase_next = PH_SRV_LO;
                end
                PH_SRV_LO: begin
                    rem_next = rem_dec;
                    v  = {8'd0, acc_next[7:0], s_data_byte};
                    lx = {8'd0, acc_next[23:8]};
                    if (v < 24'd4 || v + 24'd2 > lx) begin
                        pend_next = ST_NOT; phase_next = PH_WAIT;
                    end else begin
                        acc_next = lx - 24'd3; phase_next = PH_NTYPE;
                    end
                end
                PH_NTYPE: begin
                    rem_next = rem_dec;
                    phase_next = (s_data_byte != 8'd0) ? PH_EXT_SKIP : PH_NLEN_HI;
                end
                PH_NLEN_HI: begin
                    rem_next = rem_dec;
                    acc_next = {16'd0, s_data_byte};
                    phase_next = PH_NLEN_LO;
                end
                PH_NLEN_LO: begin
                    flen_next = {acc_next[7:0], s_data_byte};
                    foff_next = 14'(p + 17'd1);
                    pend_next = ST_FOUND; phase_next = PH_WAIT;
                end
                PH_EXT_SKIP: begin
                    rem_next = rem_dec;
                    if (acc_next != '0) acc_next = acc_next - 24'd1;
                    if (acc_next == '0) begin
                        if (rem_dec < 24'd4) begin
                            pend_next = ST_NOT; phase_next = PH_WAIT;
                        end else phase_next = PH_EXT_TYPE_HI;
                    end
                end
                PH_WAIT: ;
                default: ;
            endcase

            // Header violations report at once; otherwise the end of the body decides.
            if (early) begin
                emit = 1'b1; emit_code = early_code;
            end else if (phase_next >= PH_CVER_MAJ &&
                         {8'd0, p} + 25'd1 == hend_next) begin
                emit = 1'b1;
                emit_code = (phase_next == PH_WAIT) ? pend_next : ST_NOT;
            end
        end
        if (!given_next && !emit && s_last_byte) begin
            emit = 1'b1; emit_code = ST_SHORT;
        end
        if (emit) given_next = 1'b1;
    end

    // Parser state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TYPE;
            pos_reg       <= '0;
            hend_reg      <= '0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            pend_reg      <= ST_NOT;
            foff_reg      <= '0;
            flen_reg      <= '0;
            given_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                hend_reg  <= hend_next;
                rem_reg   <= rem_next;
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                foff_reg  <= foff_next;
                flen_reg  <= flen_next;
                given_reg <= given_next;
            end
            if (take && emit) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_status_reg <= emit_code;
            out_off_reg    <= (emit_code == ST_FOUND) ? foff_next : '0;
            out_len_reg    <= (emit_code == ST_FOUND) ? flen_next : '0;
        end
    end

    `TCH_ASSERT_NEXT(a_emit_sets_given, aclk, aresetn, take && emit, given_reg)
    `TCH_ASSERT_IMP(a_given_no_emit, aclk, aresetn, given_reg && !s_first_byte, !emit)
    `TCH_ASSERT_IMP(a_found_in_wait, aclk, aresetn,
        take && emit && emit_code == ST_FOUND, phase_next == PH_WAIT)
    `TCH_ASSERT_IMP(a_pos_bounded, aclk, aresetn, 1'b1, pos_reg <= 17'(BufferBytes))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import tch_pkg::*;

    localparam int unsigned CycleLimit = 3000000;

    // Parser phases, in protocol order.
    typedef enum logic [4:0] {
        P_TYPE, P_MAJOR, P_MINOR, P_RLEN_HI, P_RLEN_LO, P_MSG, P_HLEN0, P_HLEN1,
        P_HLEN2, P_CVER_MAJ, P_CVER_MIN, P_RANDOM, P_SID_LEN, P_SID, P_CIPH_HI,
        P_CIPH_LO, P_CIPH, P_COMP_LEN, P_COMP, P_EXTS_HI, P_EXTS_LO,
        P_EXT_TYPE_HI, P_EXT_TYPE_LO, P_EXT_LEN_HI, P_EXT_LEN_LO, P_SRV_HI,
        P_SRV_LO, P_NTYPE, P_NLEN_HI, P_NLEN_LO, P_EXT_SKIP, P_WAIT
    } hello_phase_e;

    // Host name kinds the hello builder can produce.
    typedef enum int {SNI_HOST, SNI_OTHER_TYPE, SNI_ABSENT, SNI_BAD_LIST} sni_kind_e;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] offset;
        logic [15:0] length;
    } verdict_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        bit         typed;
        verdict_t   result;
    } byte_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [13:0] m_name_offset;
    logic [15:0] m_name_length;

    tls_client_hello_sni_extractor_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_name_offset (m_name_offset),
        .m_name_length (m_name_length)
    );

    verdict_t   verdict_q[$];
    logic [7:0] hello_bytes[$];
    int         mismatches;
    int         items_sent;
    int         verdicts_seen;
    int unsigned cycles;
    bit         hold_req;
    int         burst_left;

    // Parser state of the predictor.
    hello_phase_e ph;
    int unsigned  pos;
    longint       hs_end;
    int unsigned  sec_left;
    int unsigned  acc;
    logic [1:0]   pend;
    logic [13:0]  found_off;
    logic [15:0]  found_len;
    bit           done;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void parser_restart();
        ph = P_TYPE;
        pos = 0;
        hs_end = 0;
        sec_left = 0;
        acc = 0;
        pend = ST_NOT;
        found_off = '0;
        found_len = '0;
        done = 1'b0;
    endfunction

    function automatic void settle(logic [1:0] v);
        pend = v;
        ph = P_WAIT;
    endfunction

    function automatic void next_extension();
        if (sec_left < 4) settle(ST_NOT);
        else ph = P_EXT_TYPE_HI;
    endfunction

    function automatic void enter_ciphers(int unsigned p);
        if (hs_end - longint'(p) - 1 < 4) settle(ST_NOT);
        else ph = P_CIPH_HI;
    endfunction

    function automatic void count_down();
        if (sec_left > 0) sec_left--;
    endfunction

    // One byte through the phase logic; returns a verdict to give now, or -1.
    function automatic int parse_byte(int unsigned b, int unsigned p);
        longint      r;
        int unsigned v;
        int unsigned lx;
        r = hs_end - longint'(p) - 1;
        case (ph)
            P_TYPE: begin
                if (b != REC_HANDSHAKE) return ST_NOT;
                ph = P_MAJOR;
            end
            P_MAJOR: begin
                if (b < MIN_MAJOR) return ST_NOT;
                ph = P_MINOR;
            end
            P_MINOR: ph = P_RLEN_HI;
            P_RLEN_HI: begin
                acc = b;
                ph = P_RLEN_LO;
            end
            P_RLEN_LO: begin
                v = (acc << 8) | b;
                if (v < 49) return ST_NOT;
                ph = P_MSG;
            end
            P_MSG: begin
                if (b != MSG_HELLO) return ST_NOT;
                ph = P_HLEN0;
            end
            P_HLEN0: begin
                acc = b;
                ph = P_HLEN1;
            end
            P_HLEN1: begin
                acc = (acc << 8) | b;
                ph = P_HLEN2;
            end
            P_HLEN2: begin
                v = ((acc & 32'hFFFF) << 8) | b;
                if (v < 45) return ST_NOT;
                hs_end = 9 + v;
                ph = P_CVER_MAJ;
            end
            P_CVER_MAJ: begin
                acc = (b < MIN_MAJOR) ? 1 : 0;
                ph = P_CVER_MIN;
            end
            P_CVER_MIN: begin
                if (acc != 0 || b < 1) settle(ST_NOT);
                else ph = P_RANDOM;
            end
            P_RANDOM: if (p >= LAST_RANDOM) ph = P_SID_LEN;
            P_SID_LEN: begin
                if (b > MAX_SID || longint'(b) > r) settle(ST_NOT);
                else if (b == 0) enter_ciphers(p);
                else begin
                    sec_left = b;
                    ph = P_SID;
                end
            end
            P_SID: begin
                count_down();
                if (sec_left == 0) enter_ciphers(p);
            end
            P_CIPH_HI: begin
                acc = b;
                ph = P_CIPH_LO;
            end
            P_CIPH_LO: begin
                v = ((acc & 8'hFF) << 8) | b;
                if (v < 2 || longint'(v) > r + 2 || r - longint'(v) < 2) settle(ST_NOT);
                else begin
                    sec_left = v;
                    ph = P_CIPH;
                end
            end
            P_CIPH: begin
                count_down();
                if (sec_left == 0) ph = P_COMP_LEN;
            end
            P_COMP_LEN: begin
                if (b < 1 || longint'(b) > r + 1 || r - longint'(b) < 2) settle(ST_NOT);
                else begin
                    sec_left = b;
                    ph = P_COMP;
                end
            end
            P_COMP: begin
                count_down();
                if (sec_left == 0) ph = P_EXTS_HI;
            end
            P_EXTS_HI: begin
                acc = b;
                ph = P_EXTS_LO;
            end
            P_EXTS_LO: begin
                v = ((acc & 8'hFF) << 8) | b;
                if (longint'(v) > r) settle(ST_NOT);
                else begin
                    sec_left = v;
                    next_extension();
                end
            end
            P_EXT_TYPE_HI: begin
                count_down();
                acc = b;
                ph = P_EXT_TYPE_LO;
            end
            P_EXT_TYPE_LO: begin
                count_down();
                acc = ((((acc & 8'hFF) << 8) | b) == 0) ? 32'h10000 : 0;
                ph = P_EXT_LEN_HI;
            end
            P_EXT_LEN_HI: begin
                count_down();
                acc = (acc & 32'h10000) | (b << 8);
                ph = P_EXT_LEN_LO;
            end
            P_EXT_LEN_LO: begin
                count_down();
                lx = (acc & 32'hFF00) | b;
                if (lx > sec_left) settle(ST_NOT);
                else if ((acc & 32'h10000) != 0) begin
                    if (lx < 2) settle(ST_NOT);
                    else begin
                        acc = lx << 8;
                        ph = P_SRV_HI;
                    end
                end else if (lx == 0) next_extension();
                else begin
                    acc = lx;
                    ph = P_EXT_SKIP;
                end
            end
            P_SRV_HI: begin
                count_down();
                acc = (acc & 32'hFFFF00) | b;
                ph = P_SRV_LO;
            end
            P_SRV_LO: begin
                count_down();
                v = ((acc & 8'hFF) << 8) | b;
                lx = (acc >> 8) & 32'hFFFF;
                if (v < 4 || v + 2 > lx) settle(ST_NOT);
                else begin
                    acc = lx - 3;
                    ph = P_NTYPE;
                end
            end
            P_NTYPE: begin
                count_down();
                ph = (b != 0) ? P_EXT_SKIP : P_NLEN_HI;
            end
            P_NLEN_HI: begin
                count_down();
                acc = b;
                ph = P_NLEN_LO;
            end
            P_NLEN_LO: begin
                found_len = ((acc & 8'hFF) << 8) | b;
                found_off = 14'(p + 1);
                settle(ST_FOUND);
            end
            P_EXT_SKIP: begin
                count_down();
                if (acc > 0) acc--;
                if (acc == 0) next_extension();
            end
            default: ;
        endcase
        return -1;
    endfunction

    // Predicts the verdict for one accepted item; returns 1 when one is due.
    function automatic bit predict_verdict(logic [7:0] b, logic first, logic last,
                                           output verdict_t res);
        int          verdict;
        int unsigned p;
        verdict = -1;
        res = '0;
        if (first) parser_restart();
        if (done) return 1'b0;
        if (pos < BufferBytes) begin
            p = pos;
            pos++;
            verdict = parse_byte(b, p);
            if (verdict < 0 && ph >= P_CVER_MAJ && p + 1 == hs_end)
                verdict = (ph == P_WAIT) ? pend : ST_NOT;
        end
        if (verdict < 0 && last) verdict = ST_SHORT;
        if (verdict < 0) return 1'b0;
        done = 1'b1;
        res.status = verdict[1:0];
        if (verdict == ST_FOUND) begin
            res.offset = found_off;
            res.length = found_len;
        end
        return 1'b1;
    endfunction

    // Offers one item, waits for acceptance, and returns at the accepting edge.
    task automatic send_byte(logic [7:0] b, logic first, logic last, bit typed = 0,
                             verdict_t typed_res = '0);
        verdict_t res;
        bit       due;
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_first_byte <= first;
        s_last_byte  <= last;
        do @(negedge aclk); while (!s_ready);
        due = predict_verdict(b, first, last, res);
        if (typed) begin
            if (due != 1'b1 || res != typed_res) due = 1'b1;
            res = typed_res;
        end
        if (due) verdict_q.push_back(res);
        items_sent++;
        @(posedge aclk);
    endtask

    // Bursts of random length separated by random gaps.
    task automatic sender_gap(bit no_gaps);
        int n;
        if (no_gaps) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 40);
        n = $urandom_range(1, 9);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_buffer(bit no_gaps);
        int n;
        n = hello_bytes.size();
        for (int i = 0; i < n; i++) begin
            sender_gap(no_gaps);
            send_byte(hello_bytes[i], i == 0, i == n - 1);
        end
    endtask

    function automatic void put16(int unsigned v);
        hello_bytes.push_back(8'(v >> 8));
        hello_bytes.push_back(8'(v));
    endfunction

    // Builds a ClientHello into hello_bytes; lengths are consistent except the name list length for SNI_BAD_LIST.
    function automatic void build_hello(sni_kind_e kind, bit tail_ext);
        logic [7:0] body[$];
        logic [7:0] exts[$];
        int unsigned name_n;
        int unsigned list_n;
        int unsigned t;
        int unsigned k;
        // Extensions: an optional other one, the server name unless the kind is SNI_ABSENT, an optional tail.
        if ($urandom_range(0, 1)) begin
            t = $urandom_range(1, 65535);
            k = $urandom_range(0, 6);
            exts.push_back(8'(t >> 8));
            exts.push_back(8'(t));
            exts.push_back(8'h00);
            exts.push_back(8'(k));
            repeat (k) exts.push_back(8'($urandom));
        end
        if (kind != SNI_ABSENT) begin
            name_n = $urandom_range(1, 24);
            list_n = 3 + name_n;
            exts.push_back(8'h00);
            exts.push_back(8'h00);
            exts.push_back(8'((list_n + 2) >> 8));
            exts.push_back(8'(list_n + 2));
            t = (kind == SNI_BAD_LIST) ? list_n + 2 : list_n;
            exts.push_back(8'(t >> 8));
            exts.push_back(8'(t));
            exts.push_back((kind == SNI_OTHER_TYPE) ? 8'($urandom_range(1, 255)) : 8'h00);
            exts.push_back(8'(name_n >> 8));
            exts.push_back(8'(name_n));
            repeat (name_n) exts.push_back(8'($urandom_range(97, 122)));
        end
        if (tail_ext) begin
            k = $urandom_range(0, 8);
            exts.push_back(8'h00);
            exts.push_back(8'h0a);
            exts.push_back(8'h00);
            exts.push_back(8'(k));
            repeat (k) exts.push_back(8'($urandom));
        end
        body.push_back(8'h03);
        body.push_back(8'h03);
        repeat (32) body.push_back(8'($urandom));
        k = $urandom_range(0, 32);
        body.push_back(8'(k));
        repeat (k) body.push_back(8'($urandom));
        k = 2 * $urandom_range(1, 4);
        body.push_back(8'h00);
        body.push_back(8'(k));
        repeat (k) body.push_back(8'($urandom));
        body.push_back(8'h01);
        body.push_back(8'h00);
        body.push_back(8'(exts.size() >> 8));
        body.push_back(8'(exts.size()));
        foreach (exts[i]) body.push_back(exts[i]);
        hello_bytes.delete();
        hello_bytes.push_back(REC_HANDSHAKE);
        hello_bytes.push_back(8'h03);
        hello_bytes.push_back(8'h01);
        put16(body.size() + 4);
        hello_bytes.push_back(MSG_HELLO);
        hello_bytes.push_back(8'h00);
        put16(body.size());
        foreach (body[i]) hello_bytes.push_back(body[i]);
    endfunction

    // Random damage: a corrupted byte, a cut, trailing bytes, or none.
    function automatic void damage_hello();
        int unsigned n;
        n = hello_bytes.size();
        case ($urandom_range(0, 7))
            0, 1: hello_bytes[$urandom_range(0, n - 1)] = 8'($urandom);
            2: begin
                n = $urandom_range(1, n - 1);
                while (hello_bytes.size() > n) void'(hello_bytes.pop_back());
            end
            3: repeat ($urandom_range(1, 5)) hello_bytes.push_back(8'($urandom));
            default: ;
        endcase
    endfunction

    // Directed rows; typed expectations are the ones plain from the protocol.
    byte_row_t rows[$];

    function automatic void add_row(logic [7:0] b, logic f, logic l, bit typed = 0,
                                    logic [1:0] st = ST_NOT);
        byte_row_t row;
        row.data = b;
        row.first = f;
        row.last = l;
        row.typed = typed;
        row.result = '{status: st, offset: '0, length: '0};
        rows.push_back(row);
    endfunction

    // Cycle limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("tls_client_hello_sni_extractor_top regression: fail");
                $finish;
            end
        end
    end

    // Receiver: stall pattern drawn anew at random from three modes, keyed to the cycle counter; long hold on request.
    initial begin
        int hold_cnt;
        int mode;
        hold_cnt = 0;
        mode = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 300;
            end
            if (cycles % 64 == 0) mode = $urandom_range(0, 2);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (mode == 0) begin
                m_ready <= 1'b1;
            end else if (mode == 1) begin
                m_ready <= $urandom_range(0, 1);
            end else begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result check, sampled mid-cycle where every signal is settled.
    always @(negedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: status %0d", m_status);
            end else begin
                want = verdict_q.pop_front();
                if (m_status !== want.status || m_name_offset !== want.offset ||
                    m_name_length !== want.length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.status, want.offset, want.length,
                                 m_status, m_name_offset, m_name_length);
                end
            end
        end
    end

    // Stimulus.
    initial begin
        int wait_cnt;
        mismatches = 0;
        items_sent = 0;
        verdicts_seen = 0;
        hold_req = 1'b0;
        burst_left = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data_byte <= '0;
        s_first_byte <= 1'b0;
        s_last_byte <= 1'b0;
        parser_restart();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Header violations, early end and bytes after a verdict.
        add_row(8'h00, 1, 0, 1, ST_NOT);
        add_row(8'hff, 1, 1, 1, ST_NOT);
        add_row(8'h16, 1, 1, 1, ST_SHORT);
        add_row(8'h16, 1, 0);
        add_row(8'h02, 0, 0, 1, ST_NOT);
        add_row(8'h16, 1, 0);
        add_row(8'hff, 0, 0);
        add_row(8'h03, 0, 0);
        add_row(8'h00, 0, 0);
        add_row(8'h30, 0, 0, 1, ST_NOT);
        add_row(8'h55, 0, 1);
        add_row(8'h16, 1, 0);
        add_row(8'h03, 0, 0);
        add_row(8'h01, 0, 0);
        add_row(8'hff, 0, 0);
        add_row(8'hff, 0, 0);
        add_row(8'h02, 0, 0, 1, ST_NOT);
        foreach (rows[i]) send_byte(rows[i].data, rows[i].first, rows[i].last,
                                    rows[i].typed, rows[i].result);

        // Whole hellos, one of each host name kind, with and without a tail.
        for (int k = 0; k < 4; k++) begin
            build_hello(sni_kind_e'(k), k[0]);
            send_buffer(1);
        end

        // Huge declared lengths: the body never completes before the last byte.
        hello_bytes.delete();
        hello_bytes.push_back(REC_HANDSHAKE);
        hello_bytes.push_back(8'h03);
        hello_bytes.push_back(8'h01);
        put16(16'hffff);
        hello_bytes.push_back(MSG_HELLO);
        hello_bytes.push_back(8'hff);
        put16(16'hffff);
        repeat (120) hello_bytes.push_back(8'h00);
        send_buffer(1);

        // Pause until everything has drained.
        while (verdict_q.size() != 0) @(posedge aclk);

        // Long receiver hold while short buffers keep coming.
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 21)), 1, 0);

        // Random part: mostly hellos with random content, some damaged, some noise.
        while (items_sent < 800) begin
            case ($urandom_range(0, 9))
                0: begin
                    hello_bytes.delete();
                    repeat ($urandom_range(1, 12)) hello_bytes.push_back(8'($urandom));
                    if ($urandom_range(0, 1)) hello_bytes[0] = REC_HANDSHAKE;
                end
                1, 2, 3: begin
                    build_hello(sni_kind_e'($urandom_range(0, 3)), $urandom_range(0, 1));
                    damage_hello();
                end
                default: build_hello(($urandom_range(0, 3) == 0) ?
                                     sni_kind_e'($urandom_range(1, 3)) : SNI_HOST,
                                     $urandom_range(0, 1));
            endcase
            send_buffer($urandom_range(0, 7) == 0);
        end
        s_valid <= 1'b0;

        // Drain, then give the output register time to empty.
        wait_cnt = 0;
        while (verdict_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (20) @(posedge aclk);
        if (verdict_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("tls_client_hello_sni_extractor_top regression: pass");
        end else begin
            $display("tls_client_hello_sni_extractor_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tch_pkg.sv
rtl/tls_client_hello_sni_extractor_top.sv
verif/testbench.sv
